/* rtl/core/hsfc_pkg.sv */
// Shared constants and types for the half/single float converter.
package hsfc_pkg;

    // Field widths of the two formats.
    localparam int unsigned C_WORD_W   = 32;
    localparam int unsigned C_HALF_W   = 16;
    localparam int unsigned C_MANT16_W = 10;
    localparam int unsigned C_EXP16_W  = 5;
    localparam int unsigned C_MANT32_W = 23;
    localparam int unsigned C_EXP32_W  = 8;

    // Exponent rebias between the formats (127 - 15).
    localparam logic [C_EXP32_W-1:0] C_EXP_REBIAS = 8'd112;

    // Half exponent codes.
    localparam logic [C_EXP16_W-1:0] C_EXP16_ZERO = 5'd0;
    localparam logic [C_EXP16_W-1:0] C_EXP16_MAX  = 5'd31;

    // Single exponent code for infinity and NaN.
    localparam logic [C_EXP32_W-1:0] C_EXP32_MAX = 8'hff;

    // Lowest half exponent still rounded into a subnormal.
    localparam int C_TINY_LIMIT = -10;

    // Half special encodings.
    localparam logic [C_HALF_W-1:0] C_INF16  = 16'h7c00;
    localparam logic [C_HALF_W-1:0] C_QNAN16 = 16'h7e00;

    // Rounding increment at the single mantissa scale.
    localparam logic [C_MANT32_W:0] C_ROUND_HALF = 24'h001000;

    // Conversion direction codes.
    typedef enum logic {
        ACT_H2S = 1'b0,
        ACT_S2H = 1'b1
    } t_action;

endpackage : hsfc_pkg

/* rtl/core/hsfc_h2s.sv */
// Half to single conversion: exact widening with subnormal normalization.
module hsfc_h2s (
    input  logic [hsfc_pkg::C_HALF_W-1:0] i_half,
    output logic [hsfc_pkg::C_WORD_W-1:0] o_single
);
    import hsfc_pkg::*;

    localparam logic [C_EXP32_W-1:0] C_SUB_BIAS = C_EXP_REBIAS - 8'(C_MANT16_W - 1);

    logic                   sign;
    logic [C_EXP16_W-1:0]   expo;
    logic [C_MANT16_W-1:0]  mant;
    logic [3:0]             lead_pos;
    logic [C_MANT16_W:0]    norm;
    logic [C_EXP32_W-1:0]   sub_exp;

    assign sign = i_half[C_HALF_W-1];
    assign expo = i_half[C_HALF_W-2 -: C_EXP16_W];
    assign mant = i_half[C_MANT16_W-1:0];

    // Locate the leading one of a subnormal mantissa.
    always_comb begin
        lead_pos = 4'd0;
        for (int i = 0; i < C_MANT16_W; i++) begin
            if (mant[i]) begin
                lead_pos = 4'(i);
            end
        end
    end

    // Shift the leading one into the hidden position.
    assign norm    = {1'b0, mant} << (4'(C_MANT16_W) - lead_pos);
    assign sub_exp = 8'(lead_pos) + C_SUB_BIAS;

    // Select the output encoding by exponent class.
    always_comb begin
        if (expo == C_EXP16_ZERO) begin
            if (mant == '0) begin
                o_single = {sign, 31'd0};
            end else begin
                o_single = {sign, sub_exp, norm[C_MANT16_W-1:0], 13'd0};
            end
        end else if (expo == C_EXP16_MAX) begin
            o_single = {sign, C_EXP32_MAX, mant, 13'd0};
        end else begin
            o_single = {sign, 8'(expo) + C_EXP_REBIAS, mant, 13'd0};
        end
    end

endmodule : hsfc_h2s

/* rtl/core/hsfc_s2h.sv */
// Single to half conversion: round half away from zero, subnormals, overflow.
module hsfc_s2h (
    input  logic [hsfc_pkg::C_WORD_W-1:0] i_single,
    output logic [hsfc_pkg::C_HALF_W-1:0] o_half
);
    import hsfc_pkg::*;

    localparam logic [C_EXP32_W-1:0] C_TINY_EFIELD = 8'(int'(C_EXP_REBIAS) + C_TINY_LIMIT);
    localparam logic [C_EXP32_W-1:0] C_OVF_EFIELD  = C_EXP_REBIAS + 8'(C_EXP16_MAX);
    localparam logic [C_EXP32_W-1:0] C_SUB_SHIFT   = C_EXP_REBIAS + 8'd1;

    logic                    sign;
    logic [C_EXP32_W-1:0]    efield;
    logic [C_MANT32_W-1:0]   mant;
    logic [3:0]              sub_shift;
    logic [C_MANT32_W:0]     sub_mant;
    logic [C_MANT32_W:0]     sub_round;
    logic [C_MANT32_W:0]     nrm_round;
    logic [C_EXP16_W-1:0]    nrm_exp;
    logic [C_HALF_W-2:0]     nrm_mag;

    assign sign   = i_single[C_WORD_W-1];
    assign efield = i_single[C_WORD_W-2 -: C_EXP32_W];
    assign mant   = i_single[C_MANT32_W-1:0];

    // Align and round a result that lands in the half subnormal range.
    assign sub_shift = 4'(C_SUB_SHIFT - efield);
    assign sub_mant  = {1'b1, mant} >> sub_shift;
    assign sub_round = sub_mant + C_ROUND_HALF;

    // Round a normal result; a mantissa carry adds into the exponent.
    assign nrm_round = {1'b0, mant} + C_ROUND_HALF;
    assign nrm_exp   = 5'(efield - C_EXP_REBIAS);
    assign nrm_mag   = {nrm_exp, 10'd0} + 15'(nrm_round[C_MANT32_W:13]);

    // Select the output encoding by exponent range.
    always_comb begin
        if (efield == C_EXP32_MAX) begin
            o_half = {sign, 15'd0} | ((mant == '0) ? C_INF16 : C_QNAN16);
        end else if (efield <= C_EXP_REBIAS) begin
            if (efield < C_TINY_EFIELD) begin
                o_half = {sign, 15'd0};
            end else begin
                // a rounding carry lands in the exponent LSB as the smallest normal
                o_half = {sign, 4'd0, sub_round[C_MANT32_W:13]};
            end
        end else if (efield >= C_OVF_EFIELD) begin
            o_half = {sign, 15'd0} | C_INF16;
        end else begin
            o_half = {sign, nrm_mag};
        end
    end

endmodule : hsfc_s2h

/* rtl/core/half_single_float_converter.sv */
// Top level: registered half/single float converter, one operand per cycle.
// The result strobe o_valid follows the cycle in which start is taken
// through the input register, then the result register.
// Throughput: one conversion per cycle; busy stays low, since every stage
// advances each cycle and the receiver cannot stall.
// Reset (synchronous, active low) clears the stage valid flags, so no result
// strobe follows reset until a new start is taken.
module half_single_float_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [hsfc_pkg::C_WORD_W-1:0] i_operand_bits,
    output logic                          o_valid,
    output logic [hsfc_pkg::C_WORD_W-1:0] o_result_bits
);
    import hsfc_pkg::*;

    logic                  r_in_vld;
    logic                  n_in_vld;
    t_action               r_action;
    logic [C_WORD_W-1:0]   r_operand;
    logic                  r_out_vld;
    logic [C_WORD_W-1:0]   r_result;
    logic [C_WORD_W-1:0]   n_result;
    logic [C_WORD_W-1:0]   h2s_bits;
    logic [C_HALF_W-1:0]   s2h_bits;

    // Every stage advances each cycle, so a transfer is never refused.
    assign busy     = 1'b0;
    assign n_in_vld = start & ~busy;

    // Capture the operand on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_action  <= t_action'(i_action);
            r_operand <= i_operand_bits;
        end
    end

    // Both conversion paths work on the registered operand.
    hsfc_h2s u_h2s (
        .i_half   (r_operand[C_HALF_W-1:0]),
        .o_single (h2s_bits)
    );

    hsfc_s2h u_s2h (
        .i_single (r_operand),
        .o_half   (s2h_bits)
    );

    // Pick the direction; a half result is zero-extended.
    always_comb begin
        case (r_action)
            ACT_H2S: n_result = h2s_bits;
            ACT_S2H: n_result = {16'd0, s2h_bits};
            default: n_result = h2s_bits;
        endcase
    end

    // Register the result and its strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result_bits = r_result;

endmodule : half_single_float_converter

/* rtl/core/hsfc_checker.sv */
// Port-level checker for the half/single float converter, bound to the top.
module hsfc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_action,
    input logic [hsfc_pkg::C_WORD_W-1:0] i_operand_bits,
    input logic                          o_valid,
    input logic [hsfc_pkg::C_WORD_W-1:0] o_result_bits
);
    import hsfc_pkg::*;

    // Each transfer gives a result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("missing result after transfer");

    // No result without an earlier transfer.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result strobe without a transfer");

    // Single to half results are zero-extended.
    a_half_zero_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_action == ACT_S2H, 2)) |-> (o_result_bits[31:16] == 16'd0))
        else $error("half result not zero-extended");

    // A half zero widens to a single zero of the same sign.
    a_zero_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_action == ACT_H2S, 2) && $past(i_operand_bits[14:0] == 15'd0, 2))
        |-> (o_result_bits == {$past(i_operand_bits[15], 2), 31'd0}))
        else $error("half zero converted wrongly");

endmodule : hsfc_checker

bind half_single_float_converter hsfc_checker u_hsfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_action       (i_action),
    .i_operand_bits (i_operand_bits),
    .o_valid        (o_valid),
    .o_result_bits  (o_result_bits)
);

/* bench/hsfc_conversion_checker.sv */
// Checker that predicts every half/single conversion and compares it with the result strobe.
module hsfc_conversion_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_action,
    input  logic [hsfc_pkg::C_WORD_W-1:0] i_operand_bits,
    input  logic                          i_valid,
    input  logic [hsfc_pkg::C_WORD_W-1:0] i_result_bits,
    output int                            o_mismatches,
    output int                            o_pending
);
    import hsfc_pkg::*;

    localparam int unsigned MANT_DROP = C_MANT32_W - C_MANT16_W;

    typedef struct {
        t_action             act;
        logic [C_WORD_W-1:0] operand;
        logic [C_WORD_W-1:0] result;
    } t_conversion;

    t_conversion pending_conv[$];
    int          mismatch_count = 0;

    // Widen a half pattern to single; exact, subnormals get normalized.
    function automatic logic [C_WORD_W-1:0] widen_half(logic [C_HALF_W-1:0] h);
        logic [C_WORD_W-1:0]  sign;
        logic [C_EXP16_W-1:0] expo;
        logic [C_MANT16_W:0]  mant;
        logic [C_EXP32_W-1:0] wide_exp;
        sign = {h[C_HALF_W-1], {(C_WORD_W-1){1'b0}}};
        expo = h[C_HALF_W-2:C_MANT16_W];
        mant = {1'b0, h[C_MANT16_W-1:0]};
        if (expo == C_EXP16_ZERO) begin
            if (mant == '0)
                return sign;
            // shift until the hidden bit appears, lowering the exponent each step
            wide_exp = C_EXP_REBIAS + 8'd1;
            while (!mant[C_MANT16_W]) begin
                mant     = mant << 1;
                wide_exp = wide_exp - 8'd1;
            end
            return sign | {1'b0, wide_exp, mant[C_MANT16_W-1:0], {MANT_DROP{1'b0}}};
        end
        // infinity and NaN keep their payload, no quieting
        if (expo == C_EXP16_MAX)
            return sign | {1'b0, C_EXP32_MAX, mant[C_MANT16_W-1:0], {MANT_DROP{1'b0}}};
        wide_exp = C_EXP_REBIAS + expo;
        return sign | {1'b0, wide_exp, mant[C_MANT16_W-1:0], {MANT_DROP{1'b0}}};
    endfunction

    // Narrow a single pattern to half, rounding half away from zero.
    function automatic logic [C_HALF_W-1:0] narrow_single(logic [C_WORD_W-1:0] f);
        logic [C_HALF_W-1:0]   sign;
        logic [C_MANT32_W:0]   shifted;
        logic [C_WORD_W-1:0]   rounded;
        logic [C_EXP32_W-1:0]  efield;
        logic [C_MANT32_W-1:0] mant;
        int                    half_exp;
        sign     = {f[C_WORD_W-1], {(C_HALF_W-1){1'b0}}};
        efield   = f[C_WORD_W-2:C_MANT32_W];
        mant     = f[C_MANT32_W-1:0];
        half_exp = int'(efield) - int'(C_EXP_REBIAS);
        if (efield == C_EXP32_MAX)
            return sign | ((mant == '0) ? C_INF16 : C_QNAN16);
        if (half_exp <= 0) begin
            // flush far-below-range values, else round into a subnormal
            if (half_exp < C_TINY_LIMIT)
                return sign;
            shifted = {1'b1, mant} >> (1 - half_exp);
            rounded = (32'(shifted) + 32'(C_ROUND_HALF)) >> MANT_DROP;
            return sign | rounded[C_HALF_W-1:0];
        end
        if (half_exp >= int'(C_EXP16_MAX))
            return sign | C_INF16;
        // a mantissa carry adds into the exponent
        rounded = (32'(half_exp) << C_MANT16_W)
                + ((32'(mant) + 32'(C_ROUND_HALF)) >> MANT_DROP);
        return sign | rounded[C_HALF_W-1:0];
    endfunction

    // Print one line and count it.
    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Record each accepted transfer, then match each strobed result to the oldest one.
    always @(posedge i_clk) begin
        t_conversion conv;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                conv.act     = t_action'(i_action);
                conv.operand = i_operand_bits;
                if (conv.act == ACT_H2S)
                    conv.result = widen_half(i_operand_bits[C_HALF_W-1:0]);
                else
                    conv.result = {{(C_WORD_W-C_HALF_W){1'b0}}, narrow_single(i_operand_bits)};
                pending_conv.push_back(conv);
            end
            if (i_valid) begin
                if (pending_conv.size() == 0) begin
                    report_mismatch($sformatf("result %h with no conversion pending",
                                              i_result_bits));
                end else begin
                    conv = pending_conv.pop_front();
                    if (i_result_bits !== conv.result)
                        report_mismatch($sformatf("%s of %h gave result_bits %h, predicted %h",
                                                  conv.act.name(), conv.operand,
                                                  i_result_bits, conv.result));
                end
            end
        end
        o_pending    <= pending_conv.size();
        o_mismatches <= mismatch_count;
    end

endmodule : hsfc_conversion_checker

/* bench/half_single_float_converter_tb.sv */
// Testbench top: drives conversions into the converter and gives the verdict.
module half_single_float_converter_tb;
    import hsfc_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 6;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    t_action             action       = ACT_H2S;
    logic [C_WORD_W-1:0] operand_bits = '0;
    logic                busy;
    logic                res_valid;
    logic [C_WORD_W-1:0] result_bits;
    int                  mismatches;
    int                  pending;
    int                  cycle_count  = 0;
    bit                  no_gaps      = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    half_single_float_converter DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (action),
        .i_operand_bits (operand_bits),
        .o_valid        (res_valid),
        .o_result_bits  (result_bits)
    );

    hsfc_conversion_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (action),
        .i_operand_bits (operand_bits),
        .i_valid        (res_valid),
        .i_result_bits  (result_bits),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Hold start low over an idle stretch of length n while the payload ports carry noise.
    task automatic idle_for(int n);
        start <= 1'b0;
        repeat (n) begin
            action       <= t_action'($urandom_range(1));
            operand_bits <= $urandom();
            @(posedge clk);
        end
    endtask

    // Offer one conversion, wait for its transfer, then maybe idle (about 7 in 100 conversions).
    task automatic send_conversion(t_action act, logic [C_WORD_W-1:0] bits);
        start        <= 1'b1;
        action       <= act;
        operand_bits <= bits;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (!no_gaps && $urandom_range(99) < 7)
            idle_for($urandom_range(1, MAX_GAP));
    endtask

    // Stop sending until every predicted result has come back.
    task automatic drain_conversions();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Half operand with random upper bits, biased toward zero, subnormal and max exponents.
    function automatic logic [C_WORD_W-1:0] random_half_word();
        logic [C_EXP16_W-1:0]  expo;
        logic [C_MANT16_W-1:0] mant;
        logic [C_WORD_W-1:0]   word;
        word = $urandom();
        mant = C_MANT16_W'($urandom());
        case ($urandom_range(3))
            0:       expo = C_EXP16_ZERO;
            1:       expo = C_EXP16_MAX;
            default: expo = C_EXP16_W'($urandom());
        endcase
        if ($urandom_range(5) == 0)
            mant = '0;
        word[C_HALF_W-2:0] = {expo, mant};
        return word;
    endfunction

    // Single operand biased toward the half range edges and rounding boundaries.
    function automatic logic [C_WORD_W-1:0] random_single_word();
        logic [C_EXP32_W-1:0]  expo;
        logic [C_MANT32_W-1:0] mant;
        mant = C_MANT32_W'($urandom());
        case ($urandom_range(4))
            0:       return $urandom();
            1:       expo = C_EXP32_W'($urandom_range(98, 114));
            2:       expo = C_EXP32_W'($urandom_range(113, 145));
            3:       expo = $urandom_range(1) ? C_EXP32_MAX : '0;
            default: expo = C_EXP32_W'($urandom());
        endcase
        case ($urandom_range(4))
            0:       mant[12:0] = 13'h1000;
            1:       mant[12:0] = 13'h0fff;
            2:       mant = '1;
            3:       mant = '0;
            default: ;
        endcase
        return {1'($urandom()), expo, mant};
    endfunction

    initial begin
        t_action act;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // half to single: zeros, subnormals, normals, infinities, NaN payload, upper bits
        send_conversion(ACT_H2S, 32'h0000_0000);
        send_conversion(ACT_H2S, 32'h0000_8000);
        send_conversion(ACT_H2S, 32'h0000_0001);
        send_conversion(ACT_H2S, 32'h0000_83ff);
        send_conversion(ACT_H2S, 32'h0000_0400);
        send_conversion(ACT_H2S, 32'h0000_7bff);
        send_conversion(ACT_H2S, 32'h0000_7c00);
        send_conversion(ACT_H2S, 32'h0000_fc00);
        send_conversion(ACT_H2S, 32'h0000_7c01);
        send_conversion(ACT_H2S, 32'habcd_ffff);
        send_conversion(ACT_H2S, 32'hffff_3c00);
        // single to half: zeros, single subnormal, infinity, NaN, overflow, rounding carry
        send_conversion(ACT_S2H, 32'h0000_0000);
        send_conversion(ACT_S2H, 32'h8000_0000);
        send_conversion(ACT_S2H, 32'h0000_0001);
        send_conversion(ACT_S2H, 32'h7f80_0000);
        send_conversion(ACT_S2H, 32'hff80_0001);
        send_conversion(ACT_S2H, 32'h7fff_ffff);
        send_conversion(ACT_S2H, 32'h477f_e000);
        send_conversion(ACT_S2H, 32'h477f_f000);
        send_conversion(ACT_S2H, 32'hc780_0000);
        send_conversion(ACT_S2H, 32'h7f7f_ffff);
        send_conversion(ACT_S2H, 32'h3f80_1000);
        // tiny values: smallest subnormal, tie rounding up to it, flush, carry into normal
        send_conversion(ACT_S2H, 32'h3380_0000);
        send_conversion(ACT_S2H, 32'hb300_0000);
        send_conversion(ACT_S2H, 32'h3280_0000);
        send_conversion(ACT_S2H, 32'h387f_ffff);
        drain_conversions();

        // random conversions, with a gap-free stretch in the middle
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_gaps = (i >= 150 && i < 250);
            if (i == 300)
                drain_conversions();
            act = t_action'($urandom_range(1));
            send_conversion(act, (act == ACT_H2S) ? random_half_word() : random_single_word());
        end

        drain_conversions();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule : half_single_float_converter_tb
